@@ rtl/sist_pkg.sv @@
// Shared types and constants for the sorted integer set table.
// No dependencies; the files that use it refer to this package by scoped names.
package sist_pkg;

  localparam int VALUE_W = 32;
  localparam int KIND_W  = 2;
  localparam int POS_W   = 6;
  localparam int COUNT_W = 7;

  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic signed [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic               found;
    logic [POS_W-1:0]   position;
    logic [COUNT_W-1:0] count;
    logic               rejected;
  } rsp_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic                      cmp;  // capture compare flags
    logic                      ins;  // insert commit
    logic                      del;  // remove commit
    logic signed [VALUE_W-1:0] value;
  } cell_ctrl_t;

endpackage

@@ rtl/sist_chan_if.sv @@
// Valid/ready channel carrying one payload of type T per transaction.
// Depends on nothing; payload types come from sist_pkg at instantiation.
interface sist_chan_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/sorted_integer_set_table_core.sv @@
// Top level of the sorted integer set table: controller plus a row of cells.
// Depends on sist_pkg, sist_chan_if and sist_cell.
//
// Holds up to CAPACITY distinct signed 32-bit values in ascending order, one
// per cell. Each request transaction on req is an add, remove or membership
// query (an unused kind code acts as a query) and yields exactly one response
// transaction on rsp with found (present before the operation), position,
// the entry count afterwards and rejected (add of a new value to a full
// table). One request is handled at a time. The request is latched at the
// accepting edge, and its response is registered when the update commits:
// first every cell compares its entry with the value in parallel, then the
// lower bound is encoded from the cells' flags and, on an insert or remove,
// every cell at or above it shifts by one place toward or away from its
// neighbor. The controller then returns to idle. A new request is taken
// once the previous one has committed, even while its response still waits
// in the output register; commit holds only while that register is full
// and not being drained. No clearing pass is needed after reset: only cells
// below the entry count take part in a compare.
module sorted_integer_set_table_core #(
  parameter int CAPACITY = 64
) (
  input  logic                clk,
  input  logic                rst,
  sist_chan_if.sink           req,
  sist_chan_if.source         rsp
);

  localparam int CW = $clog2(CAPACITY + 1);  // count and lower-bound width

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0]    state;
  logic [1:0]    state_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  // Latched request.
  logic [sist_pkg::KIND_W-1:0]         op_kind;
  logic signed [sist_pkg::VALUE_W-1:0] op_value;

  logic          rsp_valid;
  sist_pkg::rsp_t rsp_data;

  sist_pkg::cell_ctrl_t ctrl;

  logic signed [sist_pkg::VALUE_W-1:0] cell_entry [CAPACITY];
  logic [CAPACITY-1:0] less_vec;
  logic [CAPACITY-1:0] eq_vec;
  logic [CAPACITY-1:0] edge_vec;  // one-hot: first cell not below the value

  logic          commit;
  logic          found;
  logic          full;
  logic          do_ins;
  logic          do_del;
  logic          rejected;
  logic [CW-1:0] lb_or;
  logic [CW-1:0] lb;
  logic [31:0]   pos_wide;
  logic [31:0]   count_wide;

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  // Commit when the output register is free or being drained this cycle.
  assign commit = (state == S_UPD) && (!rsp_valid || rsp.ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (req.valid) state_next = S_CMP;
      S_CMP:  state_next = S_UPD;
      S_UPD:  if (commit) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op_kind  <= req.data.kind;
      op_value <= req.data.value;
    end
  end

  // Decision from the cell flags; flags form a thermometer below the bound.
  assign found    = |eq_vec;
  assign full     = (count >= CW'(CAPACITY));
  assign do_ins   = (op_kind == sist_pkg::KIND_ADD) && !found && !full;
  assign do_del   = (op_kind == sist_pkg::KIND_REMOVE) && found;
  assign rejected = (op_kind == sist_pkg::KIND_ADD) && !found && full;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (i == 0) begin
        edge_vec[i] = !less_vec[i];
      end else begin
        edge_vec[i] = !less_vec[i] && less_vec[i-1];
      end
    end
  end

  always_comb begin
    lb_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (edge_vec[i]) lb_or = lb_or | CW'(i);
    end
  end

  assign lb = (|edge_vec) ? lb_or : CW'(CAPACITY);

  always_comb begin
    count_next = count;
    if (do_ins) begin
      count_next = count + CW'(1);
    end else if (do_del) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (commit) begin
      count <= count_next;
    end
  end

  // Response register; fields masked to the fixed port widths.
  assign pos_wide   = (found || do_ins) ? 32'(lb) : 32'd0;
  assign count_wide = 32'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      rsp_data.found    <= found;
      rsp_data.position <= pos_wide[sist_pkg::POS_W-1:0];
      rsp_data.count    <= count_wide[sist_pkg::COUNT_W-1:0];
      rsp_data.rejected <= rejected;
    end
  end

  // Broadcast to the cells.
  assign ctrl.cmp   = (state == S_CMP);
  assign ctrl.ins   = commit && do_ins;
  assign ctrl.del   = commit && do_del;
  assign ctrl.value = op_value;

  // Row of cells; cell 0 sees a "less" left neighbor so it can take the
  // value, the last cell sees itself on the right.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic                                left_less;
    logic signed [sist_pkg::VALUE_W-1:0] left_entry;
    logic signed [sist_pkg::VALUE_W-1:0] right_entry;

    if (g == 0) begin : g_first
      assign left_less  = 1'b1;
      assign left_entry = cell_entry[g];
    end else begin : g_mid
      assign left_less  = less_vec[g-1];
      assign left_entry = cell_entry[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_entry = cell_entry[g];
    end else begin : g_inner
      assign right_entry = cell_entry[g+1];
    end

    sist_cell #(
      .INDEX (g),
      .CW    (CW)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .count       (count),
      .left_less   (left_less),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (cell_entry[g]),
      .less        (less_vec[g]),
      .eq          (eq_vec[g])
    );
  end

endmodule

@@ rtl/sist_cell.sv @@
// One table cell: holds one entry, compares it with the broadcast value
// and shifts toward or away from its neighbors. Depends on sist_pkg.
module sist_cell #(
  parameter int INDEX = 0,
  parameter int CW    = 7
) (
  input  logic                               clk,
  input  sist_pkg::cell_ctrl_t               ctrl,
  input  logic [CW-1:0]                      count,
  input  logic                               left_less,
  input  logic signed [sist_pkg::VALUE_W-1:0] left_entry,
  input  logic signed [sist_pkg::VALUE_W-1:0] right_entry,
  output logic signed [sist_pkg::VALUE_W-1:0] entry,
  output logic                               less,
  output logic                               eq
);

  logic cell_valid;

  assign cell_valid = (CW'(INDEX) < count);

  // Flags are captured once per transaction and used by the commit cycle.
  always_ff @(posedge clk) begin
    if (ctrl.cmp) begin
      less <= cell_valid && (entry < ctrl.value);
      eq   <= cell_valid && (entry == ctrl.value);
    end
  end

  // Cells at or above the lower bound move: right on insert, left on remove.
  always_ff @(posedge clk) begin
    if (ctrl.ins && !less) begin
      entry <= left_less ? ctrl.value : left_entry;
    end else if (ctrl.del && !less) begin
      entry <= right_entry;
    end
  end

endmodule

@@ rtl/sist_checker.sv @@
// Port-level checks for sorted_integer_set_table_core, bound to the top.
// Depends on sist_pkg for field widths.
module sist_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic                         rsp_found,
  input logic [sist_pkg::POS_W-1:0]   rsp_position,
  input logic [sist_pkg::COUNT_W-1:0] rsp_count,
  input logic                         rsp_rejected
);

  // Stalled response must stay presented.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  // Stalled response payload must not change.
  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_found) && $stable(rsp_position)
      && $stable(rsp_count) && $stable(rsp_rejected))
    else $error("response payload changed while stalled");

  // One request in flight: no second transaction right after one is taken.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in flight");

  // A refused add reports an absent value at position zero.
  a_reject_shape: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_rejected |-> !rsp_found && (rsp_position == '0))
    else $error("rejected response with found or position set");

  // Reset leaves no response pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid right after reset");

endmodule

bind sorted_integer_set_table_core sist_checker u_sist_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_found    (rsp.data.found),
  .rsp_position (rsp.data.position),
  .rsp_count    (rsp.data.count),
  .rsp_rejected (rsp.data.rejected)
);

@@ tb/sorted_integer_set_table_core_test.sv @@
`timescale 1ns / 100ps
// Testbench for sorted_integer_set_table_core: directed table, then random add/remove/query.
// Depends on sist_pkg, sist_chan_if and the core RTL; checks against a queue-based set model.
module sorted_integer_set_table_core_test;

  localparam int TABLE_CAP      = 64;
  localparam int RAND_PER_PHASE = 310;   // three idle phases, ~930 random transactions
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transaction on either channel
  localparam int DRAIN_CYCLES   = 8;     // quiet time after the last response

  // Kind code with no operation of its own; the core handles it as a query.
  localparam logic [sist_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam logic signed [sist_pkg::VALUE_W-1:0] VAL_LO = 32'sh8000_0000;
  localparam logic signed [sist_pkg::VALUE_W-1:0] VAL_HI = 32'sh7FFF_FFFF;

  typedef struct {
    sist_pkg::req_t op;
    bit             typed;     // expectation written into the table rather than predicted
    sist_pkg::rsp_t typed_rsp;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sist_chan_if #(.T(sist_pkg::req_t)) req_if (.clk(clk));
  sist_chan_if #(.T(sist_pkg::rsp_t)) rsp_if (.clk(clk));

  sorted_integer_set_table_core #(
    .CAPACITY(TABLE_CAP)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req(req_if.sink),
    .rsp(rsp_if.source)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the table contents, kept ascending, plus the responses still owed.
  logic signed [sist_pkg::VALUE_W-1:0] shadow_set[$];
  sist_pkg::rsp_t                      awaited_rsp[$];

  int unsigned src_idle_pct  = 33;
  int unsigned sink_idle_pct = 77;
  int          fail_count    = 0;
  int          quiet_cycles  = 0;

  // Random traffic runs in episodes: fill the table until it has been seen full
  // a few times (so full-table rejects happen), then drain it down to empty.
  bit growing     = 1'b1;
  int full_hits   = 0;
  int empty_hits  = 0;

  dir_row_t dir_rows[$];

  // ---------------------------------------------------------------------------
  // Set model: one request in, the response it owes out. Lower bound by linear
  // scan over signed values; insert/remove shift the queue like the cell row.
  // ---------------------------------------------------------------------------
  function automatic sist_pkg::rsp_t set_step(input sist_pkg::req_t op);
    logic signed [sist_pkg::VALUE_W-1:0] v;
    int             idx;
    bit             present;
    sist_pkg::rsp_t res;
    v   = op.value;
    idx = 0;
    while (idx < shadow_set.size() && shadow_set[idx] < v) idx++;
    present      = (idx < shadow_set.size()) && (shadow_set[idx] == v);
    res          = '0;
    res.found    = present;
    if (present) res.position = sist_pkg::POS_W'(idx);
    if (op.kind == sist_pkg::KIND_ADD) begin
      if (!present) begin
        if (shadow_set.size() >= TABLE_CAP) begin
          // full table: dropped, position stays 0
          res.rejected = 1'b1;
        end else begin
          shadow_set.insert(idx, v);
          res.position = sist_pkg::POS_W'(idx);
        end
      end
    end else if (op.kind == sist_pkg::KIND_REMOVE) begin
      if (present) shadow_set.delete(idx);
    end
    // query and the unused code leave the set alone
    res.count = sist_pkg::COUNT_W'(shadow_set.size());
    return res;
  endfunction

  // Directed rows: typed expectation, or left to the model.
  function automatic dir_row_t row_known(input logic [sist_pkg::KIND_W-1:0] kind,
                                         input logic signed [sist_pkg::VALUE_W-1:0] value,
                                         input bit f, input int pos, input int cnt,
                                         input bit rej);
    dir_row_t r;
    r.op.kind             = kind;
    r.op.value            = value;
    r.typed               = 1'b1;
    r.typed_rsp.found     = f;
    r.typed_rsp.position  = sist_pkg::POS_W'(pos);
    r.typed_rsp.count     = sist_pkg::COUNT_W'(cnt);
    r.typed_rsp.rejected  = rej;
    return r;
  endfunction

  function automatic dir_row_t row_modeled(input logic [sist_pkg::KIND_W-1:0] kind,
                                           input logic signed [sist_pkg::VALUE_W-1:0] value);
    dir_row_t r;
    r.op.kind  = kind;
    r.op.value = value;
    r.typed    = 1'b0;
    r.typed_rsp = '0;
    return r;
  endfunction

  // Value mix: corners, a narrow band around zero (dense neighbors and
  // duplicates) and full-range words so every bit toggles.
  function automatic logic signed [sist_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(5))
          0: return VAL_LO;
          1: return VAL_HI;
          2: return VAL_LO + 1;
          3: return VAL_HI - 1;
          4: return -1;
          default: return 0;
        endcase
      end
      1, 2, 3: return sist_pkg::VALUE_W'(int'($urandom_range(80)) - 40);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [sist_pkg::VALUE_W-1:0] pick_member();
    if (shadow_set.size() == 0) return pick_value();
    return shadow_set[$urandom_range(shadow_set.size() - 1)];
  endfunction

  // Next random request, chosen from the current shadow state.
  function automatic sist_pkg::req_t next_random_op();
    sist_pkg::req_t op;
    int unsigned    roll;
    roll = $urandom_range(99);
    if (growing && shadow_set.size() == TABLE_CAP) begin
      full_hits++;
      if (full_hits > 8) begin
        growing   = 1'b0;
        full_hits = 0;
      end
    end else if (!growing && shadow_set.size() == 0) begin
      empty_hits++;
      if (empty_hits > 3) begin
        growing    = 1'b1;
        empty_hits = 0;
      end
    end
    op.value = pick_value();
    if (growing) begin
      if (roll < 60) begin
        op.kind = sist_pkg::KIND_ADD;
      end else if (roll < 70) begin
        op.kind  = sist_pkg::KIND_ADD;          // duplicate add
        op.value = pick_member();
      end else if (roll < 80) begin
        op.kind  = sist_pkg::KIND_QUERY;
        op.value = pick_member();
      end else if (roll < 88) begin
        op.kind = sist_pkg::KIND_QUERY;
      end else if (roll < 95) begin
        op.kind  = sist_pkg::KIND_REMOVE;
        op.value = pick_member();
      end else begin
        op.kind = KIND_UNUSED;
        if ($urandom_range(1)) op.value = pick_member();
      end
    end else begin
      if (roll < 60) begin
        op.kind  = sist_pkg::KIND_REMOVE;
        op.value = pick_member();
      end else if (roll < 70) begin
        op.kind = sist_pkg::KIND_REMOVE;        // mostly absent values
      end else if (roll < 80) begin
        op.kind  = sist_pkg::KIND_QUERY;
        op.value = pick_member();
      end else if (roll < 88) begin
        op.kind = sist_pkg::KIND_ADD;
      end else if (roll < 95) begin
        op.kind = sist_pkg::KIND_QUERY;
      end else begin
        op.kind = KIND_UNUSED;
        if ($urandom_range(1)) op.value = pick_member();
      end
    end
    return op;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side. Called at a rising edge; optionally idles, then holds valid
  // with the payload until the transaction is taken. valid is never dropped
  // and raised in the same step. The model runs at the accepting edge.
  // ---------------------------------------------------------------------------
  task automatic send_op(input sist_pkg::req_t op, input bit typed,
                         input sist_pkg::rsp_t typed_rsp);
    sist_pkg::rsp_t model_rsp;
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= op;
    do @(posedge clk); while (!req_if.ready);
    model_rsp = set_step(op);
    awaited_rsp.push_back(typed ? typed_rsp : model_rsp);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Response side: random backpressure, and every response transaction is
  // compared with the oldest owed one.
  // ---------------------------------------------------------------------------
  sist_pkg::rsp_t rsp_want;
  sist_pkg::rsp_t rsp_got;

  always @(posedge clk) begin
    rsp_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      rsp_got = rsp_if.data;
      if (awaited_rsp.size() == 0) begin
        $error("response with none owed: found %0d position %0d count %0d rejected %0d",
               rsp_got.found, rsp_got.position, rsp_got.count, rsp_got.rejected);
        fail_count++;
      end else begin
        rsp_want = awaited_rsp.pop_front();
        check_field("found", rsp_want.found, rsp_got.found);
        check_field("position", rsp_want.position, rsp_got.position);
        check_field("count", rsp_want.count, rsp_got.count);
        check_field("rejected", rsp_want.rejected, rsp_got.rejected);
      end
    end
  end

  // Watchdog: a long stretch with no transaction on either side means a hang.
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed table, three random phases, drain.
  // ---------------------------------------------------------------------------
  initial begin
    req_if.valid = 1'b0;
    req_if.data  = '0;

    dir_rows = '{
      // empty table: query and remove miss
      row_known(sist_pkg::KIND_QUERY, 0, 1'b0, 0, 0, 1'b0),
      row_known(sist_pkg::KIND_REMOVE, 5, 1'b0, 0, 0, 1'b0),
      // extremes go to the ends, zero lands between them
      row_known(sist_pkg::KIND_ADD, VAL_LO, 1'b0, 0, 1, 1'b0),
      row_known(sist_pkg::KIND_ADD, VAL_HI, 1'b0, 1, 2, 1'b0),
      row_known(sist_pkg::KIND_ADD, 0, 1'b0, 1, 3, 1'b0),
      // duplicate add reports the existing slot
      row_known(sist_pkg::KIND_ADD, 0, 1'b1, 1, 3, 1'b0),
      row_known(sist_pkg::KIND_QUERY, VAL_HI, 1'b1, 2, 3, 1'b0),
      row_known(sist_pkg::KIND_QUERY, -1, 1'b0, 0, 3, 1'b0),
      // unused kind code behaves as a query
      row_known(KIND_UNUSED, 0, 1'b1, 1, 3, 1'b0),
      row_known(KIND_UNUSED, 12345, 1'b0, 0, 3, 1'b0),
      // remove the head, then miss on it
      row_known(sist_pkg::KIND_REMOVE, VAL_LO, 1'b1, 0, 2, 1'b0),
      row_known(sist_pkg::KIND_REMOVE, VAL_LO, 1'b0, 0, 2, 1'b0),
      row_modeled(sist_pkg::KIND_ADD, -1),
      row_modeled(sist_pkg::KIND_ADD, 32'sh5555_5555),
      row_modeled(sist_pkg::KIND_ADD, 32'shAAAA_AAAA),
      row_modeled(sist_pkg::KIND_QUERY, 32'sh5555_5555),
      row_modeled(sist_pkg::KIND_REMOVE, 0),
      row_modeled(sist_pkg::KIND_REMOVE, VAL_HI),
      row_modeled(sist_pkg::KIND_ADD, VAL_LO),
      row_modeled(sist_pkg::KIND_QUERY, VAL_LO)
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Phase 0: sender idles 33%, receiver 77%. Directed rows run here.
    src_idle_pct  = 33;
    sink_idle_pct = 77;
    foreach (dir_rows[i]) send_op(dir_rows[i].op, dir_rows[i].typed, dir_rows[i].typed_rsp);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          src_idle_pct  = 33;
          sink_idle_pct = 77;
        end
        1: begin
          src_idle_pct  = 77;
          sink_idle_pct = 33;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      repeat (RAND_PER_PHASE) send_op(next_random_op(), 1'b0, '0);
    end
    req_if.valid <= 1'b0;

    // Wait for every owed response, then a short quiet window for strays.
    while (awaited_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
